### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the percolation block.
// Relies on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/gpuf_pkg.sv
// Shared types and helpers of the percolation union-find block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gpuf_pkg;

    // grid sites plus virtual top and virtual bottom
    function automatic int node_count(input int side);
        return side * side + 2;
    endfunction

    // sequencer states, one-hot
    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_CHECK   = 14'b00000000000100,
        S_OPEN_RD = 14'b00000000001000,
        S_OPEN_CK = 14'b00000000010000,
        S_NB      = 14'b00000000100000,
        S_NB_CK   = 14'b00000001000000,
        S_FA_RD   = 14'b00000010000000,
        S_FA_CK   = 14'b00000100000000,
        S_FB_RD   = 14'b00001000000000,
        S_FB_CK   = 14'b00010000000000,
        S_LINK1   = 14'b00100000000000,
        S_LINK2   = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } t_state;

endpackage
`default_nettype wire

### hdl/gpuf_store.sv
// Forest and open-map storage with the clearing sweep after reset.
// Depends on gpuf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gpuf_store
    import gpuf_pkg::*;
#(
    parameter int MAX_SIDE = 32
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire [$clog2(node_count(MAX_SIDE)+1)-1:0] i_node_rd_addr,
    input  wire                                      i_node_wr_en,
    input  wire [$clog2(node_count(MAX_SIDE)+1)-1:0] i_node_wr_addr,
    input  wire [$clog2(node_count(MAX_SIDE)+1)-1:0] i_node_wr_parent,
    input  wire [$clog2(node_count(MAX_SIDE)+1)-1:0] i_node_wr_size,
    output logic [$clog2(node_count(MAX_SIDE)+1)-1:0] o_node_rd_parent,
    output logic [$clog2(node_count(MAX_SIDE)+1)-1:0] o_node_rd_size,
    input  wire [((MAX_SIDE*MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1)-1:0] i_open_rd_addr,
    input  wire                                      i_open_wr_en,
    input  wire [((MAX_SIDE*MAX_SIDE > 1) ? $clog2(MAX_SIDE*MAX_SIDE) : 1)-1:0] i_open_wr_addr,
    output logic                                     o_open_rd_data,
    output logic                                     o_busy
);
    localparam int NUM_NODES = node_count(MAX_SIDE);
    localparam int NUM_SITES = MAX_SIDE * MAX_SIDE;
    // node count is never a power of two, so one width covers index and size
    localparam int NW = $clog2(NUM_NODES + 1);
    localparam int SW = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;

    logic [2*NW-1:0] r_node_mem [NUM_NODES];
    logic            r_open_mem [NUM_SITES];
    logic [NW-1:0]   r_clr_cnt;
    logic            r_busy;
    logic [2*NW-1:0] r_node_q;

    // clearing sweep, one node per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_busy    <= 1'b1;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == NW'(NUM_NODES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // parent and size word per node
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_node_mem[r_clr_cnt] <= {r_clr_cnt, NW'(1)};
        end else if (i_node_wr_en) begin
            r_node_mem[i_node_wr_addr] <= {i_node_wr_parent, i_node_wr_size};
        end
        r_node_q <= r_node_mem[i_node_rd_addr];
    end

    // open bit per site
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_clr_cnt < NW'(NUM_SITES)) begin
                r_open_mem[r_clr_cnt[SW-1:0]] <= 1'b0;
            end
        end else if (i_open_wr_en) begin
            r_open_mem[i_open_wr_addr] <= 1'b1;
        end
        o_open_rd_data <= r_open_mem[i_open_rd_addr];
    end

    assign o_node_rd_parent = r_node_q[2*NW-1:NW];
    assign o_node_rd_size   = r_node_q[NW-1:0];
    assign o_busy           = r_busy;
endmodule
`default_nettype wire

### hdl/grid_percolation_union_find.sv
// Percolation grid with weighted quick-union forest and virtual top/bottom.
// A check reads the site's open bit and then walks virtual top and bottom to their roots;
// an open first joins the site with each open neighbour, walking both trees per join.
// Throughput: one word at a time; next word accepted after the result is taken.
// Reset: synchronous active low; a clearing sweep of all nodes follows, during which no
// word is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module grid_percolation_union_find
    import gpuf_pkg::*;
#(
    parameter int MAX_SIDE = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [5:0]  i_cfg_data,     // grid_size
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [0] func, [6:1] row, [12:7] column, rest zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] site_is_open, [1] percolates, [2] range_error
);
    localparam int NUM_NODES = node_count(MAX_SIDE);
    localparam int NUM_SITES = MAX_SIDE * MAX_SIDE;
    localparam int NW = $clog2(NUM_NODES + 1);
    localparam int SW = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
    localparam int GW = $clog2(MAX_SIDE + 1);
    localparam logic [NW-1:0] NODE_TOP = NW'(NUM_SITES);
    localparam logic [NW-1:0] NODE_BOT = NW'(NUM_SITES + 1);

    t_state        r_state, n_state;
    logic [GW-1:0] r_grid;
    logic          r_func;
    logic [5:0]    r_row, r_col;
    logic [NW-1:0] r_cur, n_cur;
    logic [1:0]    r_step, n_step;
    logic [NW-1:0] r_b, n_b;
    logic [NW-1:0] r_walk, n_walk;
    logic [NW-1:0] r_ra, n_ra, r_sa, n_sa, r_rb, n_rb, r_sb, n_sb;
    logic          r_perc, n_perc;
    logic          r_open_res, n_open_res;
    logic          r_err, n_err;
    logic          r_out_perc, n_out_perc;

    logic [NW-1:0] rd_parent, rd_size;
    logic          open_rd;
    logic          busy;
    logic          node_wr_en;
    logic [NW-1:0] node_wr_addr, node_wr_parent, node_wr_size;
    logic          open_wr_en;
    logic [SW-1:0] open_rd_addr;
    logic [NW-1:0] site_idx;
    logic          in_range;
    logic          nb_valid, nb_virt;
    logic [NW-1:0] nb_node;
    logic [NW-1:0] size_sum;
    logic          a_smaller;

    gpuf_store #(.MAX_SIDE(MAX_SIDE)) u_store (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_node_rd_addr  (r_walk),
        .i_node_wr_en    (node_wr_en),
        .i_node_wr_addr  (node_wr_addr),
        .i_node_wr_parent(node_wr_parent),
        .i_node_wr_size  (node_wr_size),
        .o_node_rd_parent(rd_parent),
        .o_node_rd_size  (rd_size),
        .i_open_rd_addr  (open_rd_addr),
        .i_open_wr_en    (open_wr_en),
        .i_open_wr_addr  (site_idx[SW-1:0]),
        .o_open_rd_data  (open_rd),
        .o_busy          (busy)
    );

    // grid size register, clamped to 1..MAX_SIDE on write; only taken between words
    assign o_cfg_ready = (r_state == S_IDLE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= GW'(MAX_SIDE);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_data == 6'd0) begin
                r_grid <= GW'(1);
            end else if (7'(i_cfg_data) > 7'(MAX_SIDE)) begin
                r_grid <= GW'(MAX_SIDE);
            end else begin
                r_grid <= GW'(i_cfg_data);
            end
        end
    end

    // site decode
    assign in_range = (r_row != 6'd0) && (r_col != 6'd0)
                   && (7'(r_row) <= 7'(r_grid)) && (7'(r_col) <= 7'(r_grid));
    assign site_idx = NW'((r_row - 6'd1) * MAX_SIDE + (r_col - 6'd1));

    // neighbour of the current site for this join step
    always_comb begin
        nb_valid = 1'b1;
        nb_virt  = 1'b0;
        nb_node  = r_cur;
        case (r_step)
            2'd0: begin
                if (r_row == 6'd1) begin
                    nb_virt = 1'b1;
                    nb_node = NODE_TOP;
                end else begin
                    nb_node = r_cur - NW'(MAX_SIDE);
                end
            end
            2'd1: begin
                if (7'(r_row) == 7'(r_grid)) begin
                    nb_virt = 1'b1;
                    nb_node = NODE_BOT;
                end else begin
                    nb_node = r_cur + NW'(MAX_SIDE);
                end
            end
            2'd2: begin
                nb_valid = (r_col > 6'd1);
                nb_node  = r_cur - 1'b1;
            end
            default: begin
                nb_valid = (7'(r_col) < 7'(r_grid));
                nb_node  = r_cur + 1'b1;
            end
        endcase
    end

    assign open_rd_addr = (r_state == S_NB && !nb_virt) ? nb_node[SW-1:0] : r_cur[SW-1:0];
    assign open_wr_en   = (r_state == S_CHECK) && in_range && !r_func;
    assign size_sum     = r_sa + r_sb;
    assign a_smaller    = (r_sa < r_sb);

    // link writes of a union
    always_comb begin
        node_wr_en     = 1'b0;
        node_wr_addr   = r_ra;
        node_wr_parent = r_ra;
        node_wr_size   = r_sa;
        if (r_state == S_LINK1) begin
            node_wr_en = 1'b1;
            if (a_smaller) begin
                node_wr_addr   = r_ra;
                node_wr_parent = r_rb;
                node_wr_size   = r_sa;
            end else begin
                node_wr_addr   = r_rb;
                node_wr_parent = r_ra;
                node_wr_size   = r_sb;
            end
        end else if (r_state == S_LINK2) begin
            node_wr_en   = 1'b1;
            node_wr_size = size_sum;
            if (a_smaller) begin
                node_wr_addr   = r_rb;
                node_wr_parent = r_rb;
            end else begin
                node_wr_addr   = r_ra;
                node_wr_parent = r_ra;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_step     = r_step;
        n_b        = r_b;
        n_walk     = r_walk;
        n_ra       = r_ra;
        n_sa       = r_sa;
        n_rb       = r_rb;
        n_sb       = r_sb;
        n_perc     = r_perc;
        n_open_res = r_open_res;
        n_err      = r_err;
        n_out_perc = r_out_perc;
        unique case (r_state)
            S_CLEAR: begin
                if (!busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_cur  = site_idx;
                n_step = 2'd0;
                if (!in_range) begin
                    n_err      = 1'b1;
                    n_open_res = 1'b0;
                    n_state    = S_NB;
                    n_step     = 2'd3;
                    n_perc     = 1'b1;
                    n_walk     = NODE_TOP;
                    n_b        = NODE_BOT;
                    n_state    = S_FA_RD;
                end else if (r_func) begin
                    n_err   = 1'b0;
                    n_state = S_OPEN_RD;
                end else begin
                    n_err      = 1'b0;
                    n_open_res = 1'b1;
                    n_state    = S_NB;
                end
            end
            S_OPEN_RD: n_state = S_OPEN_CK;
            S_OPEN_CK: begin
                n_open_res = open_rd;
                n_perc     = 1'b1;
                n_walk     = NODE_TOP;
                n_b        = NODE_BOT;
                n_state    = S_FA_RD;
            end
            S_NB: begin
                n_perc = 1'b0;
                n_b    = nb_node;
                n_walk = r_cur;
                if (!nb_valid) begin
                    if (r_step == 2'd3) begin
                        n_perc  = 1'b1;
                        n_walk  = NODE_TOP;
                        n_b     = NODE_BOT;
                        n_state = S_FA_RD;
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end else if (nb_virt) begin
                    n_state = S_FA_RD;
                end else begin
                    n_state = S_NB_CK;
                end
            end
            S_NB_CK: begin
                if (open_rd) begin
                    n_state = S_FA_RD;
                end else if (r_step == 2'd3) begin
                    n_perc  = 1'b1;
                    n_walk  = NODE_TOP;
                    n_b     = NODE_BOT;
                    n_state = S_FA_RD;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = S_NB;
                end
            end
            S_FA_RD: n_state = S_FA_CK;
            S_FA_CK: begin
                if (rd_parent == r_walk) begin
                    n_ra    = r_walk;
                    n_sa    = rd_size;
                    n_walk  = r_b;
                    n_state = S_FB_RD;
                end else begin
                    n_walk  = rd_parent;
                    n_state = S_FA_RD;
                end
            end
            S_FB_RD: n_state = S_FB_CK;
            S_FB_CK: begin
                if (rd_parent != r_walk) begin
                    n_walk  = rd_parent;
                    n_state = S_FB_RD;
                end else if (r_perc) begin
                    n_out_perc = (r_ra == r_walk);
                    n_state    = S_DONE;
                end else if (r_ra != r_walk) begin
                    n_rb    = r_walk;
                    n_sb    = rd_size;
                    n_state = S_LINK1;
                end else if (r_step == 2'd3) begin
                    n_perc  = 1'b1;
                    n_walk  = NODE_TOP;
                    n_b     = NODE_BOT;
                    n_state = S_FA_RD;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = S_NB;
                end
            end
            S_LINK1: n_state = S_LINK2;
            S_LINK2: begin
                if (r_step == 2'd3) begin
                    n_perc  = 1'b1;
                    n_walk  = NODE_TOP;
                    n_b     = NODE_BOT;
                    n_state = S_FA_RD;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = S_NB;
                end
            end
            S_DONE: begin
                if (m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_func <= s_axis_tdata[0];
            r_row  <= s_axis_tdata[6:1];
            r_col  <= s_axis_tdata[12:7];
        end
        r_cur      <= n_cur;
        r_step     <= n_step;
        r_b        <= n_b;
        r_walk     <= n_walk;
        r_ra       <= n_ra;
        r_sa       <= n_sa;
        r_rb       <= n_rb;
        r_sb       <= n_sb;
        r_perc     <= n_perc;
        r_open_res <= n_open_res;
        r_err      <= n_err;
        r_out_perc <= n_out_perc;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_DONE);
    assign m_axis_tdata  = {5'd0, r_err, r_out_perc, r_open_res};

    // checks
    `ASSERT_IMPL(a_busy_during_result, m_axis_tvalid, !s_axis_tready)
    `ASSERT_NEXT(a_single_word, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid)
    `ASSERT_IMPL(a_err_closed, m_axis_tvalid && m_axis_tdata[2], !m_axis_tdata[0])
    `ASSERT_IMPL(a_grid_range, 1'b1, r_grid != '0 && 7'(r_grid) <= 7'(MAX_SIDE))
endmodule
`default_nettype wire
